// ===== rtl/rwrt_pkg.sv =====
// Shared types, constants and codes of the receive window reorder tracker.
`default_nettype none

package rwrt_pkg;

  // Field widths fixed by the segment and acknowledgement formats.
  localparam int SEQ_W    = 31;
  localparam int HANDLE_W = 16;
  localparam int WS_W     = 5;
  localparam int KIND_W   = 2;

  // Default number of physical slots.
  localparam int DEPTH_DEFAULT = 16;

  // Window size after reset.
  localparam logic [WS_W-1:0] WS_RESET = 5'd8;

  // Operation codes of an input word.
  localparam logic OP_ARRIVE = 1'b0;
  localparam logic OP_DRAIN  = 1'b1;

  // Kind codes of a result word.
  typedef enum logic [KIND_W-1:0] {
    KIND_ACK    = 2'd0,
    KIND_SEG    = 2'd1,
    KIND_STATUS = 2'd2
  } kind_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ARR_DIFF,
    ST_ARR_PUT,
    ST_ARR_SCAN,
    ST_DRN_SCAN,
    ST_COUNT,
    ST_DELIVER,
    ST_FINAL
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic diff;
    logic put;
    logic scan_arr;
    logic scan_drn;
    logic count;
    logic deliver;
    logic load_final;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_drain;
    logic cnt_zero;
    logic room;
  } sts_t;

endpackage

`default_nettype wire

// ===== rtl/rwrt_ctrl.sv =====
// Controller state machine of the receive window reorder tracker.
`default_nettype none

module rwrt_ctrl import rwrt_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic item_valid,
  input  wire logic op,
  output logic      item_stall,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (item_valid) begin
          state_next = (op == OP_DRAIN) ? ST_DRN_SCAN : ST_ARR_DIFF;
        end
      end
      ST_ARR_DIFF: state_next = ST_ARR_PUT;
      ST_ARR_PUT:  state_next = ST_ARR_SCAN;
      ST_ARR_SCAN: state_next = ST_COUNT;
      ST_DRN_SCAN: state_next = ST_COUNT;
      ST_COUNT: begin
        state_next = sts.is_drain ? ST_DELIVER : ST_FINAL;
      end
      ST_DELIVER: begin
        if (sts.cnt_zero) begin
          state_next = ST_FINAL;
        end
      end
      ST_FINAL: begin
        if (sts.room) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Commands and input stall.
  always_comb begin
    cmd        = '0;
    item_stall = 1'b1;
    case (state)
      ST_IDLE: begin
        item_stall  = 1'b0;
        cmd.capture = item_valid;
      end
      ST_ARR_DIFF: cmd.diff     = 1'b1;
      ST_ARR_PUT:  cmd.put      = 1'b1;
      ST_ARR_SCAN: cmd.scan_arr = 1'b1;
      ST_DRN_SCAN: cmd.scan_drn = 1'b1;
      ST_COUNT:    cmd.count    = 1'b1;
      ST_DELIVER:  cmd.deliver  = sts.room && !sts.cnt_zero;
      ST_FINAL:    cmd.load_final = sts.room;
      default: begin
        cmd        = '0;
        item_stall = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/rwrt_dp.sv =====
// Datapath of the receive window reorder tracker: slots, scan, counters, output register.
`default_nettype none

module rwrt_dp import rwrt_pkg::*; #(
  parameter int WINDOW_DEPTH = DEPTH_DEFAULT
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire cmd_t                cmd,
  output sts_t                     sts,
  input  wire logic                cfg_wr,
  input  wire logic [WS_W-1:0]     cfg_data,
  input  wire logic                op,
  input  wire logic [SEQ_W-1:0]    seq_num,
  input  wire logic                eof_mark,
  input  wire logic [HANDLE_W-1:0] payload_handle,
  output logic                     result_valid,
  input  wire logic                result_stall,
  output logic [KIND_W-1:0]        kind,
  output logic [SEQ_W-1:0]         seq_out,
  output logic [HANDLE_W-1:0]      handle_out,
  output logic [SEQ_W-1:0]         next_expected,
  output logic [WS_W-1:0]          free_slots,
  output logic                     accepted,
  output logic                     transfer_done,
  output logic                     last
);

  localparam int IDX_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
  localparam int CMP_W = (CNT_W > WS_W) ? CNT_W : WS_W;
  localparam int POS_W = SEQ_W + 1;

  // Effective window size: zero acts as one, large values as the depth.
  function automatic logic [CNT_W-1:0] clamp_window(input logic [WS_W-1:0] ws);
    logic [CMP_W-1:0] ext;
    ext = CMP_W'(ws);
    if (ws == '0) begin
      return CNT_W'(1);
    end else if (ext > CMP_W'(WINDOW_DEPTH)) begin
      return CNT_W'(WINDOW_DEPTH);
    end
    return CNT_W'(ext);
  endfunction

  logic [CNT_W-1:0]        eff_win;

  // Captured input word.
  logic                    op_r;
  logic [SEQ_W-1:0]        seq_r;
  logic                    eof_r;
  logic [HANDLE_W-1:0]     handle_r;

  // Window state.
  logic [SEQ_W-1:0]        slot_seq    [WINDOW_DEPTH];
  logic [HANDLE_W-1:0]     slot_handle [WINDOW_DEPTH];
  logic [WINDOW_DEPTH-1:0] slot_full;
  logic [SEQ_W-1:0]        expected;
  logic [CNT_W-1:0]        fill_index;
  logic [SEQ_W-1:0]        last_read;
  logic [SEQ_W-1:0]        eof_p1;
  logic                    eof_known;

  // Working registers.
  logic                    seq_ok;
  logic [SEQ_W-1:0]        diff;
  logic                    acc_r;
  logic                    ack_r;
  logic [CNT_W-1:0]        cnt;
  logic [CNT_W-1:0]        free_r;

  // Combinational terms.
  logic [WINDOW_DEPTH-1:0] win_mask;
  logic [WINDOW_DEPTH-1:0] empty;
  logic [WINDOW_DEPTH-1:0] counted;
  logic [CNT_W-1:0]        gap;
  logic [CNT_W-1:0]        gap_m1;
  logic [SEQ_W-1:0]        scan_expected;
  logic [CNT_W-1:0]        occ;
  logic [POS_W-1:0]        pos;
  logic [IDX_W-1:0]        pos_idx;
  logic                    hit;
  logic                    done;
  logic                    room;

  // Window mask and first empty slot inside the window.
  always_comb begin
    for (int i = 0; i < WINDOW_DEPTH; i++) begin
      win_mask[i] = CNT_W'(i) < eff_win;
    end
    empty = ~slot_full | ~win_mask;
    gap   = CNT_W'(WINDOW_DEPTH);
    for (int i = WINDOW_DEPTH - 1; i >= 0; i--) begin
      if (empty[i]) begin
        gap = CNT_W'(i);
      end
    end
    gap_m1 = gap - CNT_W'(1);
  end

  // Next expected number from the gap scan.
  assign scan_expected = (gap == '0) ? last_read + SEQ_W'(1)
                                     : slot_seq[gap_m1[IDX_W-1:0]] + SEQ_W'(1);

  // Occupied slots inside the window once the drained run has gone.
  always_comb begin
    counted = (slot_full >> cnt) & win_mask;
    occ     = '0;
    for (int i = 0; i < WINDOW_DEPTH; i++) begin
      occ = occ + CNT_W'(counted[i]);
    end
  end

  // Target slot of an arriving segment.
  assign pos     = {1'b0, diff} + POS_W'(fill_index);
  assign pos_idx = pos[IDX_W-1:0];
  assign hit     = seq_ok && (pos < POS_W'(eff_win)) && !slot_full[pos_idx];

  assign done = eof_known && (expected == eof_p1);
  assign room = !result_valid || !result_stall;

  assign sts.is_drain = op_r;
  assign sts.cnt_zero = (cnt == '0);
  assign sts.room     = room;

  // Window size register.
  always_ff @(posedge clk) begin
    if (rst) begin
      eff_win <= clamp_window(WS_RESET);
    end else if (cfg_wr) begin
      eff_win <= clamp_window(cfg_data);
    end
  end

  // Input capture and arrival checks.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r     <= op;
      seq_r    <= seq_num;
      eof_r    <= eof_mark;
      handle_r <= payload_handle;
    end
    if (cmd.diff) begin
      seq_ok <= (seq_r >= expected) && (seq_r != '0);
      diff   <= seq_r - expected;
    end
    if (cmd.put) begin
      acc_r <= hit;
    end
    if (cmd.scan_drn) begin
      ack_r <= (gap == eff_win) && !done;
    end
    if (cmd.count) begin
      free_r <= eff_win - occ;
    end
  end

  // Slot occupancy: set on a stored arrival, shifted down on each delivery.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_full <= '0;
    end else if (cmd.put && hit) begin
      slot_full[pos_idx] <= 1'b1;
    end else if (cmd.deliver) begin
      slot_full <= slot_full >> 1;
    end
  end

  // Slot contents follow the occupancy bits.
  always_ff @(posedge clk) begin
    if (cmd.put && hit) begin
      slot_seq[pos_idx]    <= seq_r;
      slot_handle[pos_idx] <= handle_r;
    end else if (cmd.deliver) begin
      for (int i = 0; i < WINDOW_DEPTH - 1; i++) begin
        slot_seq[i]    <= slot_seq[i+1];
        slot_handle[i] <= slot_handle[i+1];
      end
      slot_seq[WINDOW_DEPTH-1]    <= '0;
      slot_handle[WINDOW_DEPTH-1] <= '0;
    end
  end

  // Sequence tracking state.
  always_ff @(posedge clk) begin
    if (rst) begin
      expected   <= SEQ_W'(1);
      fill_index <= '0;
      last_read  <= '0;
      eof_p1     <= SEQ_W'(1);
      eof_known  <= 1'b0;
      cnt        <= '0;
    end else begin
      if (cmd.capture) begin
        cnt <= '0;
      end
      if (cmd.put && hit && eof_r) begin
        eof_p1    <= seq_r + SEQ_W'(1);
        eof_known <= 1'b1;
      end
      if (cmd.scan_arr) begin
        fill_index <= gap;
        expected   <= scan_expected;
      end
      if (cmd.scan_drn) begin
        fill_index <= '0;
        cnt        <= gap;
      end
      if (cmd.deliver) begin
        last_read <= slot_seq[0];
        cnt       <= cnt - CNT_W'(1);
      end
    end
  end

  // Output word valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.deliver || cmd.load_final) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  // Output word payload.
  always_ff @(posedge clk) begin
    if (cmd.deliver) begin
      kind          <= KIND_SEG;
      seq_out       <= slot_seq[0];
      handle_out    <= slot_handle[0];
      next_expected <= expected;
      free_slots    <= WS_W'(free_r);
      accepted      <= 1'b0;
      transfer_done <= done;
      last          <= 1'b0;
    end else if (cmd.load_final) begin
      if (op_r && !ack_r) begin
        kind <= KIND_STATUS;
      end else begin
        kind <= KIND_ACK;
      end
      seq_out       <= '0;
      handle_out    <= '0;
      next_expected <= expected;
      free_slots    <= WS_W'(free_r);
      accepted      <= !op_r && acc_r;
      transfer_done <= done;
      last          <= 1'b1;
    end
  end

  // A new word is never loaded over one that is still stalled.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.deliver || cmd.load_final) |-> !(result_valid && result_stall))
    else $error("output word overwritten while stalled");

  // Every delivered segment comes from an occupied front slot.
  a_deliver_full: assert property (@(posedge clk) disable iff (rst)
    cmd.deliver |-> slot_full[0])
    else $error("delivery from an empty slot");

  // The fill index and the delivery count never pass the depth.
  a_counts_bounded: assert property (@(posedge clk) disable iff (rst)
    (fill_index <= CNT_W'(WINDOW_DEPTH)) && (cnt <= CNT_W'(WINDOW_DEPTH)))
    else $error("fill index or delivery count out of range");

  // Only the acknowledgement of an arrival can report a stored segment.
  a_accept_on_ack: assert property (@(posedge clk) disable iff (rst)
    (result_valid && accepted) |-> (kind == KIND_ACK) && last)
    else $error("accepted flag on a word other than an arrival ACK");

endmodule

`default_nettype wire

// ===== rtl/receive_window_reorder_tracker.sv =====
// Top level of the receive window reorder tracker: controller and datapath.
//
//   Channel   Handshake                 Payload
//   item      item_valid / item_stall   op, seq_num, eof_mark, payload_handle
//   result    result_valid/result_stall kind, seq_out, handle_out, next_expected,
//                                       free_slots, accepted, transfer_done, last
//   cfg       cfg_valid / cfg_ready     cfg_data (window size)
//
// An arrival passes from acceptance to the next acceptance through the check,
// slot write, gap scan, free count and loading the acknowledgement word.
// A drain does the gap scan, free count and one delivery per segment; the single
// shared shift of the slot registers moves one segment per cycle unless stalled.
// Reset is synchronous; it empties the window and sets the window size to 8.
// A stalled result holds the controller in its delivery or final state.
`default_nettype none

module receive_window_reorder_tracker import rwrt_pkg::*; #(
  parameter int WINDOW_DEPTH = DEPTH_DEFAULT
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [WS_W-1:0]     cfg_data,
  input  wire logic                item_valid,
  output logic                     item_stall,
  input  wire logic                op,
  input  wire logic [SEQ_W-1:0]    seq_num,
  input  wire logic                eof_mark,
  input  wire logic [HANDLE_W-1:0] payload_handle,
  output logic                     result_valid,
  input  wire logic                result_stall,
  output logic [KIND_W-1:0]        kind,
  output logic [SEQ_W-1:0]         seq_out,
  output logic [HANDLE_W-1:0]      handle_out,
  output logic [SEQ_W-1:0]         next_expected,
  output logic [WS_W-1:0]          free_slots,
  output logic                     accepted,
  output logic                     transfer_done,
  output logic                     last
);

  cmd_t cmd;
  sts_t sts;
  logic cfg_wr;

  // The window size register takes a write in any cycle.
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  rwrt_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .op         (op),
    .item_stall (item_stall),
    .sts        (sts),
    .cmd        (cmd)
  );

  rwrt_dp #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_wr         (cfg_wr),
    .cfg_data       (cfg_data),
    .op             (op),
    .seq_num        (seq_num),
    .eof_mark       (eof_mark),
    .payload_handle (payload_handle),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .kind           (kind),
    .seq_out        (seq_out),
    .handle_out     (handle_out),
    .next_expected  (next_expected),
    .free_slots     (free_slots),
    .accepted       (accepted),
    .transfer_done  (transfer_done),
    .last           (last)
  );

endmodule

`default_nettype wire

// ===== dv/rwrt_scoreboard_pkg.sv =====
// Scoreboard class that predicts and checks the result words of the reorder tracker.
`timescale 1ns / 100ps

package rwrt_scoreboard_pkg;
  import rwrt_pkg::*;

  localparam int SLOTS = DEPTH_DEFAULT;

  // One result word as it leaves the block.
  typedef struct packed {
    kind_t                kind;
    logic [SEQ_W-1:0]     seq;
    logic [HANDLE_W-1:0]  handle;
    logic [SEQ_W-1:0]     next_exp;
    logic [WS_W-1:0]      free;
    logic                 acc;
    logic                 done;
    logic                 last;
  } rx_word_t;

  class reorder_scoreboard;
    // Predicted window contents and bookkeeping.
    logic [WS_W-1:0]     window_size;
    logic [SEQ_W-1:0]    slot_seq[SLOTS];
    logic [HANDLE_W-1:0] slot_handle[SLOTS];
    bit                  slot_full[SLOTS];
    logic [SEQ_W-1:0]    expected_seq;
    int unsigned         fill_index;
    logic [SEQ_W-1:0]    last_read_seq;
    logic [SEQ_W-1:0]    eof_seq;
    bit                  eof_known;

    rx_word_t due_q[$];
    int errors, checked;
    int drains, stored, delivered, full_acks, done_words;

    function new();
      window_size = WS_RESET;
      foreach (slot_seq[i]) begin
        slot_seq[i] = '0;
        slot_handle[i] = '0;
        slot_full[i] = 1'b0;
      end
      expected_seq = 1;
      fill_index = 0;
      last_read_seq = '0;
      eof_seq = '0;
      eof_known = 1'b0;
    endfunction

    function void set_window(logic [WS_W-1:0] value);
      window_size = value;
    endfunction

    // A size of zero behaves as one slot, anything above the depth as the depth.
    function int unsigned eff_window();
      if (window_size < 1) return 1;
      if (window_size > SLOTS) return SLOTS;
      return window_size;
    endfunction

    function int unsigned free_count();
      int unsigned w = eff_window();
      int unsigned occ = 0;
      for (int i = 0; i < w; i++)
        if (slot_full[i]) occ++;
      return (occ >= w) ? 0 : w - occ;
    endfunction

    function bit is_done();
      return eof_known && (expected_seq == SEQ_W'(eof_seq + 1));
    endfunction

    function int pending();
      return due_q.size();
    endfunction

    // Queue one expected word; the state fields reflect the input fully applied.
    function void push(kind_t k, logic [SEQ_W-1:0] s, logic [HANDLE_W-1:0] h,
                       logic acc, logic last);
      rx_word_t r;
      r.kind = k;
      r.seq = s;
      r.handle = h;
      r.next_exp = expected_seq;
      r.free = WS_W'(free_count());
      r.acc = acc;
      r.done = is_done();
      r.last = last;
      if (r.done) done_words++;
      due_q.push_back(r);
    endfunction

    // The next expected number follows the run of occupied slots at the front.
    function void gap_scan();
      int unsigned w = eff_window();
      int unsigned j = 0;
      while (j < w && slot_full[j]) j++;
      fill_index = j;
      if (j == 0) expected_seq = SEQ_W'(last_read_seq + 1);
      else expected_seq = SEQ_W'(slot_seq[j-1] + 1);
    endfunction

    function void note_input(logic op_v, logic [SEQ_W-1:0] seq_v, logic eof_v,
                             logic [HANDLE_W-1:0] handle_v);
      int unsigned w = eff_window();
      longint unsigned pos;
      bit took = 0;
      bit ack_due;
      int unsigned n = 0;
      logic [SEQ_W-1:0] out_seq[SLOTS];
      logic [HANDLE_W-1:0] out_handle[SLOTS];

      if (op_v == OP_ARRIVE) begin
        // Old segments, duplicates and those beyond the window are dropped.
        if (seq_v >= expected_seq && seq_v != 0) begin
          pos = fill_index + (seq_v - expected_seq);
          if (pos < w && !slot_full[pos]) begin
            slot_full[pos] = 1'b1;
            slot_seq[pos] = seq_v;
            slot_handle[pos] = handle_v;
            if (eof_v) begin
              eof_seq = seq_v;
              eof_known = 1'b1;
            end
            took = 1;
            stored++;
          end
        end
        gap_scan();
        push(KIND_ACK, '0, '0, took, 1'b1);
      end else begin
        // Deliver the in-order prefix, then shift everything down by that many.
        drains++;
        ack_due = (free_count() == 0) && !is_done();
        while (n < w && slot_full[n]) begin
          out_seq[n] = slot_seq[n];
          out_handle[n] = slot_handle[n];
          last_read_seq = slot_seq[n];
          n++;
        end
        for (int i = 0; i < SLOTS; i++) begin
          if (i + n < SLOTS) begin
            slot_seq[i] = slot_seq[i+n];
            slot_handle[i] = slot_handle[i+n];
            slot_full[i] = slot_full[i+n];
          end else begin
            slot_seq[i] = '0;
            slot_handle[i] = '0;
            slot_full[i] = 1'b0;
          end
        end
        fill_index = 0;
        for (int i = 0; i < n; i++)
          push(KIND_SEG, out_seq[i], out_handle[i], 1'b0, 1'b0);
        delivered += n;
        if (ack_due) full_acks++;
        push(ack_due ? KIND_ACK : KIND_STATUS, '0, '0, 1'b0, 1'b1);
      end
    endfunction

    function string fmt(rx_word_t r);
      return $sformatf("kind %0d seq %0d handle %h next %0d free %0d acc %0b done %0b last %0b",
                       r.kind, r.seq, r.handle, r.next_exp, r.free, r.acc, r.done, r.last);
    endfunction

    // Only the first ten problems are shown; the rest are counted.
    function void flag_error(string what);
      errors++;
      if (errors <= 10) $display("%0t: %s", $time, what);
    endfunction

    function void check_result(rx_word_t got);
      rx_word_t want;
      checked++;
      if (due_q.size() == 0) begin
        flag_error({"unexpected word: ", fmt(got)});
        return;
      end
      want = due_q.pop_front();
      if (got !== want)
        flag_error({"word mismatch\n  expected ", fmt(want), "\n  actual   ", fmt(got)});
    endfunction
  endclass

endpackage

// ===== dv/testbench.sv =====
// Top-level testbench of the receive window reorder tracker.
`timescale 1ns / 100ps

module testbench;
  import rwrt_pkg::*;
  import rwrt_scoreboard_pkg::*;

  localparam int QUIET_LIMIT = 3000;
  localparam int HOLD_CYCLES = 250;

  typedef enum {PACE_STEADY, PACE_SPARSE_INPUT, PACE_SLOW_OUTPUT, PACE_LIGHT_BOTH} pace_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [WS_W-1:0]     cfg_data = '0;
  logic                item_valid = 1'b0;
  logic                item_stall;
  logic                op = OP_ARRIVE;
  logic [SEQ_W-1:0]    seq_num = '0;
  logic                eof_mark = 1'b0;
  logic [HANDLE_W-1:0] payload_handle = '0;
  logic                result_valid;
  logic                result_stall = 1'b0;
  logic [KIND_W-1:0]   kind;
  logic [SEQ_W-1:0]    seq_out;
  logic [HANDLE_W-1:0] handle_out;
  logic [SEQ_W-1:0]    next_expected;
  logic [WS_W-1:0]     free_slots;
  logic                accepted;
  logic                transfer_done;
  logic                last;

  reorder_scoreboard sb;
  int gap_pct = 0;
  int stall_pct = 0;
  bit hold_go = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int held_back = 0;

  receive_window_reorder_tracker u_top (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .item_valid(item_valid), .item_stall(item_stall), .op(op), .seq_num(seq_num),
    .eof_mark(eof_mark), .payload_handle(payload_handle),
    .result_valid(result_valid), .result_stall(result_stall), .kind(kind),
    .seq_out(seq_out), .handle_out(handle_out), .next_expected(next_expected),
    .free_slots(free_slots), .accepted(accepted), .transfer_done(transfer_done),
    .last(last)
  );

  always #5 clk = ~clk;

  // Receiver: a long hold-off when requested, otherwise random stalls.
  always @(posedge clk) begin
    if (hold_go) begin
      hold_left = HOLD_CYCLES;
      hold_go = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else begin
      result_stall <= (stall_pct > 0) && ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Every result word taken by the receiver is checked against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall)
      sb.check_result('{kind_t'(kind), seq_out, handle_out, next_expected, free_slots,
                        accepted, transfer_done, last});
    if (!rst && item_valid && item_stall) held_back++;
  end

  // Watchdog: the run is abandoned after too long without any handshake.
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  task automatic set_pace(input pace_t p);
    case (p)
      PACE_STEADY: begin
        gap_pct = 0;
        stall_pct = 0;
      end
      PACE_SPARSE_INPUT: begin
        gap_pct = 68;
        stall_pct = 0;
      end
      PACE_SLOW_OUTPUT: begin
        gap_pct = 0;
        stall_pct = 68;
      end
      default: begin
        gap_pct = 8;
        stall_pct = 8;
      end
    endcase
  endtask

  // Offer one word, possibly after a random gap, and record it once taken.
  task automatic send_word(input logic op_v, input logic [SEQ_W-1:0] seq_v,
                           input logic eof_v, input logic [HANDLE_W-1:0] handle_v);
    while (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    op <= op_v;
    seq_num <= seq_v;
    eof_mark <= eof_v;
    payload_handle <= handle_v;
    do @(posedge clk); while (item_stall);
    sb.note_input(op_v, seq_v, eof_v, handle_v);
  endtask

  task automatic arrive(input logic [SEQ_W-1:0] seq_v, input logic eof_v,
                        input logic [HANDLE_W-1:0] handle_v);
    send_word(OP_ARRIVE, seq_v, eof_v, handle_v);
  endtask

  task automatic drain();
    send_word(OP_DRAIN, '0, 1'b0, '0);
  endtask

  // Wait until every predicted word has come out, then let the block go quiet.
  task automatic settle(input int tail);
    do @(posedge clk); while (sb.pending() != 0);
    repeat (tail) @(posedge clk);
  endtask

  task automatic write_window(input logic [WS_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_window(value);
  endtask

  // Mostly segments around the next expected number, with drains, stale,
  // far-off and fully random numbers mixed in.
  task automatic send_random(input int count);
    logic [SEQ_W-1:0] exp_now;
    logic [SEQ_W-1:0] seq_v;
    int unsigned w;
    int unsigned pick;
    repeat (count) begin
      exp_now = sb.expected_seq;
      w = sb.eff_window();
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        send_word(OP_DRAIN, SEQ_W'($urandom), 1'($urandom), HANDLE_W'($urandom));
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 60)
          seq_v = exp_now + SEQ_W'($urandom_range(0, w));
        else if (pick < 70)
          seq_v = (exp_now > 20) ? exp_now - SEQ_W'($urandom_range(1, 20))
                                 : SEQ_W'($urandom_range(0, exp_now - 1));
        else if (pick < 85)
          seq_v = SEQ_W'($urandom);
        else
          seq_v = exp_now + SEQ_W'($urandom_range(w + 1, w + 40));
        send_word(OP_ARRIVE, seq_v, $urandom_range(0, 99) < 6, HANDLE_W'($urandom));
      end
    end
    item_valid <= 1'b0;
  endtask

  task automatic run_phase(input logic [WS_W-1:0] size, input pace_t p, input int count,
                           input bit hold);
    settle(8);
    write_window(size);
    set_pace(p);
    if (hold) hold_go = 1;
    send_random(count);
  endtask

  initial begin
    sb = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part with the reset window of eight slots.
    arrive(0, 1'b0, 16'h0000);               // old segment numbered zero
    arrive(1, 1'b0, 16'hFFFF);
    arrive(1, 1'b0, 16'h0001);               // now below the expected number
    arrive(4, 1'b0, 16'h1234);               // leaves a gap
    arrive(4, 1'b0, 16'h4321);               // duplicate of an occupied slot
    arrive(31'h7FFF_FFFF, 1'b1, 16'hA5A5);   // far beyond, so the end mark is ignored
    arrive(9, 1'b0, 16'h0009);               // one past the last slot
    arrive(8, 1'b0, 16'h0008);               // exactly the last slot
    arrive(3, 1'b0, 16'h0003);
    arrive(2, 1'b0, 16'h0002);               // closes the gap
    drain();
    arrive(100, 1'b1, 16'h0100);
    arrive(5, 1'b0, 16'h0005);
    arrive(6, 1'b0, 16'h0006);
    arrive(7, 1'b0, 16'h0007);
    arrive(9, 1'b0, 16'h0019);
    arrive(10, 1'b0, 16'h0010);
    arrive(11, 1'b0, 16'h0011);
    arrive(12, 1'b0, 16'h0012);              // window now full
    arrive(13, 1'b0, 16'h0013);              // no room left
    drain();                                 // full window ends with an ACK
    arrive(14, 1'b1, 16'h0014);
    arrive(13, 1'b0, 16'h0113);              // transfer complete
    drain();
    drain();                                 // nothing to deliver
    item_valid <= 1'b0;

    // Random phases over several window sizes and pacing patterns.
    run_phase(16, PACE_STEADY, 70, 1'b0);
    run_phase(0, PACE_SPARSE_INPUT, 30, 1'b0);
    run_phase(31, PACE_SLOW_OUTPUT, 60, 1'b0);
    run_phase(3, PACE_LIGHT_BOTH, 50, 1'b0);
    run_phase(17, PACE_STEADY, 60, 1'b1);
    run_phase(1, PACE_SLOW_OUTPUT, 30, 1'b0);
    run_phase(12, PACE_LIGHT_BOTH, 45, 1'b0);
    settle(20);

    $display("Run covered %0d drains, %0d stored segments, %0d delivered, %0d words checked.",
             sb.drains, sb.stored, sb.delivered, sb.checked);
    $display("Full-window ACKs %0d, done words %0d, input held back %0d cycles, errors %0d.",
             sb.full_acks, sb.done_words, held_back, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/rwrt_pkg.sv
rtl/rwrt_ctrl.sv
rtl/rwrt_dp.sv
rtl/receive_window_reorder_tracker.sv
dv/rwrt_scoreboard_pkg.sv
dv/testbench.sv
